[hdl/hsls_pkg.sv]
`default_nettype none

package hsls_pkg;

  // Steps per position count in the substep accumulator
  localparam int unsigned SubstepsPerCount = 18;

  localparam int unsigned DividerWidth = 16;
  localparam int unsigned PosWidth     = 16;
  localparam int unsigned AccWidth     = 6;
  localparam int unsigned PhaseWidth   = 4;
  localparam int unsigned CoilWidth    = 4;

  localparam logic signed [AccWidth-1:0] AccUpLimit   = AccWidth'(SubstepsPerCount);
  localparam logic signed [AccWidth-1:0] AccDownLimit = -AccWidth'(SubstepsPerCount);

  // Phase codes: idle, first of the running sequence, and the two limit stops
  localparam logic [PhaseWidth-1:0] PhaseIdle      = 4'd0;
  localparam logic [PhaseWidth-1:0] PhaseFirst     = 4'd1;
  localparam logic [PhaseWidth-1:0] PhaseOpenStop  = 4'd9;
  localparam logic [PhaseWidth-1:0] PhaseCloseStop = 4'd10;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_REARM   = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [0:0] {
    CFG_STEP_DIVIDER = 1'b0,
    CFG_DIRECTION    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DividerWidth-1:0] tick;
    logic [PhaseWidth-1:0]   phase;
    logic [CoilWidth-1:0]    coils;
    logic [PosWidth-1:0]     position;
    logic [PosWidth-1:0]     max_position;
    logic [AccWidth-1:0]     acc;
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic       open_limit_n;
    logic       close_limit_n;
  } word_t;

endpackage

`default_nettype wire

[hdl/halfstep_stepper_limit_sequencer.sv]
// Half-step sequencer for a four-coil stepper with two end-limit switches.
//
// Input channel: one word per timer tick or command (operation, open and
// close limit levels), taken when in_valid_i is high and in_stall_o low.
// Output channel: one result word per input word (coils, phase, position,
// max_position, stepped), taken when out_valid_o is high and out_stall_i low.
// Configuration: cfg_index_i selects step divider (0) or direction (1);
// cfg_ready_o is always high, so a write lands on any edge with cfg_valid_i.
// Write configuration only while no word is in flight.
//
// From acceptance, the word sits in the input register, the step logic
// then loads the result register, and its output is taken from there.
// Throughput is one word per cycle while out_stall_i stays low; the only
// loop is the state register feeding the step logic and back.
// Reset clears the divider, direction, tick count, phase, coils, position,
// max position and accumulator, and empties both pipeline registers.
// A stalled result holds in the output register; the input register still
// fills behind it, and only then is in_stall_o raised.

`default_nettype none

module halfstep_stepper_limit_sequencer
  import hsls_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [DividerWidth-1:0]    cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic                       open_limit_n_i,
  input  logic                       close_limit_n_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CoilWidth-1:0]       coils_o,
  output logic [PhaseWidth-1:0]      phase_o,
  output logic signed [PosWidth-1:0] position_o,
  output logic signed [PosWidth-1:0] max_position_o,
  output logic                       stepped_o
);

  logic [DividerWidth-1:0] step_divider_q;
  logic                    direction_q;

  state_t state_q, state_d;
  word_t  word_q;
  logic   word_valid_q;
  logic   out_valid_q;
  logic   stepped_d, stepped_q;

  logic out_ready, step_go, in_load;

  // Result register frees up when empty or being taken this cycle
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step_go    = word_valid_q && out_ready;
  assign in_stall_o = word_valid_q && !out_ready;
  assign in_load    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_divider_q <= '0;
      direction_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_DIVIDER: step_divider_q <= cfg_data_i;
        CFG_DIRECTION:    direction_q    <= cfg_data_i[0];
        default:          step_divider_q <= step_divider_q;
      endcase
    end
  end

  // Input register: hold while the result side is blocked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      word_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      word_q.operation     <= operation_i;
      word_q.open_limit_n  <= open_limit_n_i;
      word_q.close_limit_n <= close_limit_n_i;
    end
  end

  hsls_step u_step (
    .state_i        (state_q),
    .word_i         (word_q),
    .step_divider_i (step_divider_q),
    .direction_i    (direction_q),
    .state_o        (state_d),
    .stepped_o      (stepped_d)
  );

  // Motor state: advance once per word leaving the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= word_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      stepped_q <= stepped_d;
    end
  end

  // The result word mirrors the state register after its update
  assign out_valid_o    = out_valid_q;
  assign coils_o        = state_q.coils;
  assign phase_o        = state_q.phase;
  assign position_o     = $signed(state_q.position);
  assign max_position_o = $signed(state_q.max_position);
  assign stepped_o      = stepped_q;

  // Phase codes never leave the defined range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PhaseCloseStop)
    else $error("phase out of range");

  // Stopped at either limit means coils are off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PhaseOpenStop || state_q.phase == PhaseCloseStop)
      |-> state_q.coils == '0)
    else $error("coils driven while stopped at a limit");

  // A fired step restarts the divider count at one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && stepped_d |=> state_q.tick == DividerWidth'(1))
    else $error("tick count not restarted after step");

  // A step never fires with the divider at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go && stepped_d |-> step_divider_q != '0)
    else $error("step fired with divider at zero");

  // A new state is only taken with a result slot free to show it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_go |=> out_valid_q)
    else $error("state advanced without a result");

endmodule

`default_nettype wire

[hdl/hsls_step.sv]
`default_nettype none

module hsls_step
  import hsls_pkg::*;
(
  input  state_t                  state_i,
  input  word_t                   word_i,
  input  logic [DividerWidth-1:0] step_divider_i,
  input  logic                    direction_i,
  output state_t                  state_o,
  output logic                    stepped_o
);

  state_t                    st;
  logic                      fire;
  logic signed [AccWidth-1:0] acc;

  always_comb begin
    st   = state_i;
    fire = 1'b0;
    acc  = '0;
    unique case (word_i.operation)
      OP_TICK: begin
        if (step_divider_i != '0) begin
          fire = (state_i.tick > step_divider_i);
          if (fire) begin
            // limit switches first
            if (!word_i.open_limit_n) begin
              if (direction_i) begin
                st.coils = '0;
                st.phase = PhaseOpenStop;
              end
              st.position = '0;
            end
            if (!word_i.close_limit_n) begin
              if (!direction_i) begin
                st.coils = '0;
                st.phase = PhaseCloseStop;
              end
              st.max_position = st.position;
            end
            if (st.phase < PhaseOpenStop) begin
              if (!direction_i) begin
                unique case (st.phase)
                  4'd1: begin st.coils[3] = 1'b0; st.coils[0] = 1'b1; st.phase = 4'd2; end
                  4'd2: begin st.coils[1] = 1'b1; st.phase = 4'd3; end
                  4'd3: begin st.coils[0] = 1'b0; st.phase = 4'd4; end
                  4'd4: begin st.coils[2] = 1'b1; st.phase = 4'd5; end
                  4'd5: begin st.coils[1] = 1'b0; st.phase = 4'd6; end
                  4'd6: begin st.coils[3] = 1'b1; st.phase = 4'd7; end
                  4'd7: begin st.coils[2] = 1'b0; st.phase = 4'd8; end
                  4'd8: begin st.coils[0] = 1'b1; st.phase = PhaseFirst; end
                  default: st.phase = PhaseFirst;
                endcase
                acc = $signed(st.acc);
                if (acc >= AccUpLimit) begin
                  st.position = st.position + PosWidth'(1);
                  acc = '0;
                end
                st.acc = AccWidth'(acc + AccWidth'(1));
              end else begin
                unique case (st.phase)
                  4'd1: begin st.coils[0] = 1'b0; st.coils[3] = 1'b1; st.phase = 4'd2; end
                  4'd2: begin st.coils[2] = 1'b1; st.phase = 4'd3; end
                  4'd3: begin st.coils[3] = 1'b0; st.phase = 4'd4; end
                  4'd4: begin st.coils[1] = 1'b1; st.phase = 4'd5; end
                  4'd5: begin st.coils[2] = 1'b0; st.phase = 4'd6; end
                  4'd6: begin st.coils[0] = 1'b1; st.phase = 4'd7; end
                  4'd7: begin st.coils[1] = 1'b0; st.phase = 4'd8; end
                  4'd8: begin st.coils[3] = 1'b1; st.phase = PhaseFirst; end
                  default: st.phase = PhaseFirst;
                endcase
                acc = $signed(st.acc);
                if (acc <= AccDownLimit) begin
                  st.position = st.position - PosWidth'(1);
                  acc = '0;
                end
                st.acc = AccWidth'(acc - AccWidth'(1));
              end
            end
            st.tick = DividerWidth'(1);
          end else begin
            st.tick = state_i.tick + DividerWidth'(1);
          end
        end
      end
      OP_REARM:   st.phase = PhaseFirst;
      OP_RELEASE: st.coils = '0;
      default:    st = state_i;
    endcase
  end

  assign state_o   = st;
  assign stepped_o = fire;

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  import hsls_pkg::*;

  // Command code with no function; the block must leave its state alone
  localparam logic [1:0] OpSpare = 2'd3;

  // Registers between input word and result, see the head of the top level
  localparam int unsigned Latency     = 2;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned ReportLimit = 10;

  localparam logic RowWord   = 1'b0;
  localparam logic RowCfg    = 1'b1;
  localparam logic Typed     = 1'b1;
  localparam logic Predicted = 1'b0;

  typedef struct packed {
    logic [CoilWidth-1:0]  coils;
    logic [PhaseWidth-1:0] phase;
    logic [PosWidth-1:0]   position;
    logic [PosWidth-1:0]   max_position;
    logic                  stepped;
  } motor_word_t;

  // One line of the bring-up script: either a register write or an input word
  typedef struct packed {
    logic                    is_cfg;
    cfg_idx_e                reg_idx;
    logic [DividerWidth-1:0] reg_data;
    logic [1:0]              op;
    logic                    open_n;
    logic                    close_n;
    logic                    typed_in;
    motor_word_t             want;
  } script_row_t;

  localparam motor_word_t Unused = '0;
  localparam motor_word_t AtRest = '{coils: '0, phase: PhaseIdle, position: '0,
                                     max_position: '0, stepped: 1'b0};
  localparam motor_word_t FirstStep = '{coils: '0, phase: PhaseFirst, position: '0,
                                        max_position: '0, stepped: 1'b1};

  // Bring-up script. The first rows can be read straight off the reset state;
  // after the first step the predictor takes over.
  localparam int unsigned BringUpRows = 29;
  localparam script_row_t BringUp [BringUpRows] = '{
    // divider zero after reset: a tick changes nothing
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Typed,     AtRest},
    // spare command with both limits pressed: ignored
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OpSpare,    1'b0, 1'b0, Typed,     AtRest},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_RELEASE, 1'b0, 1'b0, Typed,     AtRest},
    // fastest stepping: one step every two ticks
    '{RowCfg,  CFG_STEP_DIVIDER, 16'd1,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Typed,     AtRest},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Typed,     AtRest},
    // first step out of reset moves phase zero to one, coils untouched
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Typed,     FirstStep},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    // close limit while closing: stop and latch the maximum
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b0, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b0, Predicted, Unused},
    // stopped phase: steps leave coils and accumulator alone
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_REARM,   1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_RELEASE, 1'b1, 1'b1, Predicted, Unused},
    // open the iris and run into the open limit
    '{RowCfg,  CFG_DIRECTION,    16'd1,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b0, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b0, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b0, 1'b0, Predicted, Unused},
    // divider at maximum: the tick count wraps first, so no step
    '{RowCfg,  CFG_STEP_DIVIDER, 16'hFFFF,  OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    // divider dropped below the running count: the next tick steps at once
    '{RowCfg,  CFG_STEP_DIVIDER, 16'd1,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_REARM,   1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused},
    '{RowWord, CFG_STEP_DIVIDER, 16'd0,     OP_TICK,    1'b1, 1'b1, Predicted, Unused}
  };

  // Clock, reset and every block input start at a known level
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       cfg_valid_i     = 1'b0;
  logic                       cfg_index_i     = 1'b0;
  logic [DividerWidth-1:0]    cfg_data_i      = '0;
  logic                       in_valid_i      = 1'b0;
  logic [1:0]                 operation_i     = OP_TICK;
  logic                       open_limit_n_i  = 1'b1;
  logic                       close_limit_n_i = 1'b1;
  logic                       out_stall_i     = 1'b0;
  logic                       cfg_ready_o;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [CoilWidth-1:0]       coils_o;
  logic [PhaseWidth-1:0]      phase_o;
  logic signed [PosWidth-1:0] position_o;
  logic signed [PosWidth-1:0] max_position_o;
  logic                       stepped_o;

  // Shadow of the sequencer: registers and motor state as the block should hold them
  logic [DividerWidth-1:0]    step_div  = '0;
  logic                       dir_open  = 1'b0;
  logic [DividerWidth-1:0]    tick_cnt  = '0;
  logic [PhaseWidth-1:0]      phase_now = PhaseIdle;
  logic [CoilWidth-1:0]       coil_now  = '0;
  logic [PosWidth-1:0]        pos_now   = '0;
  logic [PosWidth-1:0]        pos_peak  = '0;
  logic signed [AccWidth-1:0] acc_now   = '0;

  motor_word_t motor_expected [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;

  halfstep_stepper_limit_sequencer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .open_limit_n_i (open_limit_n_i),
    .close_limit_n_i(close_limit_n_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coils_o        (coils_o),
    .phase_o        (phase_o),
    .position_o     (position_o),
    .max_position_o (max_position_o),
    .stepped_o      (stepped_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow sequencer by one input word and return the result word
  // it should produce.
  function automatic motor_word_t sequencer_next(logic [1:0] op, logic open_n,
                                                 logic close_n);
    motor_word_t res;
    int          acc_v;
    res.stepped = 1'b0;
    case (op)
      OP_TICK: begin
        if (step_div != '0) begin
          if (tick_cnt > step_div) begin
            // limit switches are looked at on every step, stopped or not
            if (!open_n) begin
              if (dir_open) begin
                coil_now  = '0;
                phase_now = PhaseOpenStop;
              end
              pos_now = '0;
            end
            if (!close_n) begin
              if (!dir_open) begin
                coil_now  = '0;
                phase_now = PhaseCloseStop;
              end
              pos_peak = pos_now;
            end
            // any phase from the open stop upwards freezes coils and accumulator
            if (phase_now < PhaseOpenStop) begin
              if (!dir_open) begin
                case (phase_now)
                  4'd1: begin coil_now[3] = 1'b0; coil_now[0] = 1'b1; end
                  4'd2: coil_now[1] = 1'b1;
                  4'd3: coil_now[0] = 1'b0;
                  4'd4: coil_now[2] = 1'b1;
                  4'd5: coil_now[1] = 1'b0;
                  4'd6: coil_now[3] = 1'b1;
                  4'd7: coil_now[2] = 1'b0;
                  4'd8: coil_now[0] = 1'b1;
                  default: ;
                endcase
              end else begin
                case (phase_now)
                  4'd1: begin coil_now[0] = 1'b0; coil_now[3] = 1'b1; end
                  4'd2: coil_now[2] = 1'b1;
                  4'd3: coil_now[3] = 1'b0;
                  4'd4: coil_now[1] = 1'b1;
                  4'd5: coil_now[2] = 1'b0;
                  4'd6: coil_now[0] = 1'b1;
                  4'd7: coil_now[1] = 1'b0;
                  4'd8: coil_now[3] = 1'b1;
                  default: ;
                endcase
              end
              // phase zero after reset and phase eight both lead to phase one
              phase_now = (phase_now == PhaseIdle || phase_now == 4'd8) ?
                          PhaseFirst : phase_now + 4'd1;
              acc_v = acc_now;
              if (!dir_open) begin
                if (acc_v >= int'(SubstepsPerCount)) begin
                  pos_now = pos_now + 1'b1;
                  acc_v   = 0;
                end
                acc_v = acc_v + 1;
              end else begin
                if (acc_v + int'(SubstepsPerCount) <= 0) begin
                  pos_now = pos_now - 1'b1;
                  acc_v   = 0;
                end
                acc_v = acc_v - 1;
              end
              acc_now = AccWidth'(acc_v);
            end
            tick_cnt    = '0;
            res.stepped = 1'b1;
          end
          tick_cnt = tick_cnt + 1'b1;
        end
      end
      OP_REARM:   phase_now = PhaseFirst;
      OP_RELEASE: coil_now  = '0;
      default: ;
    endcase
    res.coils        = coil_now;
    res.phase        = phase_now;
    res.position     = pos_now;
    res.max_position = pos_peak;
    return res;
  endfunction

  // Offer one input word, starting and ending at a falling edge. Hold the
  // payload until the block takes it, then queue what it should produce.
  task automatic send_word(logic [1:0] op, logic open_n, logic close_n,
                           logic typed_in, motor_word_t want);
    int unsigned gap;
    motor_word_t guess;
    if (burst_left != 0) begin
      gap        = 0;
      burst_left = burst_left - 1;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 39) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    operation_i     = op;
    open_limit_n_i  = open_n;
    close_limit_n_i = close_n;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    guess = sequencer_next(op, open_n, close_n);
    motor_expected.push_back(typed_in ? want : guess);
    @(negedge clk_i);
  endtask

  // Drop the input valid and wait at a falling edge until every result is in
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (motor_expected.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Register write, issued only while the block is idle
  task automatic cfg_write(cfg_idx_e idx, logic [DividerWidth-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_STEP_DIVIDER: step_div = data;
      CFG_DIRECTION:    dir_open = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Result side stalls: free runs of random length, sometimes long ones so
  // that whole stretches go through without a stall.
  initial begin : stall_gen
    int unsigned len;
    forever begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : idle_len();
      repeat (len + 1) @(negedge clk_i);
      len = idle_len();
      if (len != 0) begin
        out_stall_i = 1'b1;
        repeat (len) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Check every accepted result word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    motor_word_t want;
    motor_word_t seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{coils: coils_o, phase: phase_o, position: position_o,
               max_position: max_position_o, stepped: stepped_o};
      if (motor_expected.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= ReportLimit)
          $display("result %0d arrived with nothing expected: coils %h phase %0d",
                   results_seen, seen.coils, seen.phase);
      end else begin
        want = motor_expected.pop_front();
        if (seen.coils !== want.coils || seen.phase !== want.phase ||
            seen.position !== want.position ||
            seen.max_position !== want.max_position ||
            seen.stepped !== want.stepped) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= ReportLimit) begin
            $display("result %0d: coils exp %h got %h, phase exp %0d got %0d,",
                     results_seen, want.coils, seen.coils, want.phase, seen.phase);
            $display("  position exp %0d got %0d, max exp %0d got %0d, stepped exp %b got %b",
                     $signed(want.position), $signed(seen.position),
                     $signed(want.max_position), $signed(seen.max_position),
                     want.stepped, seen.stepped);
          end
        end
      end
      results_seen = results_seen + 1;
    end
  end

  // Watchdog: end the run if no channel moves a word for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned             quota;
    int unsigned             counted;
    int unsigned             r;
    logic [1:0]              op;
    logic [DividerWidth-1:0] div;
    logic                    dir;

    // hold reset, then release it on a falling edge
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // walk the bring-up script
    for (int i = 0; i < BringUpRows; i++) begin
      if (BringUp[i].is_cfg) begin
        drain_results();
        cfg_write(BringUp[i].reg_idx, BringUp[i].reg_data);
      end else begin
        send_word(BringUp[i].op, BringUp[i].open_n, BringUp[i].close_n,
                  BringUp[i].typed_in, BringUp[i].want);
      end
    end

    // random phases, each under its own divider and direction
    for (int ph = 0; ph < 9; ph++) begin
      drain_results();
      if (ph == 0) div = 16'hFFFF;
      else if (ph == 1) div = 16'd1;
      else if (ph == 2) div = '0;
      else begin
        r = $urandom_range(0, 9);
        if (r == 0) div = '0;
        else if (r == 1) div = 16'hFFFF;
        else if (r < 8) div = DividerWidth'($urandom_range(1, 4));
        else if (r == 8) div = DividerWidth'($urandom_range(5, 40));
        else div = DividerWidth'($urandom_range(41, 65534));
      end
      dir = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        cfg_write(CFG_STEP_DIVIDER, div);
        cfg_write(CFG_DIRECTION, {15'($urandom()), dir});
      end else begin
        cfg_write(CFG_DIRECTION, {15'($urandom()), dir});
        cfg_write(CFG_STEP_DIVIDER, div);
      end

      // an idle motor only reacts to commands, so keep that phase short
      quota   = (div == '0) ? 30 : 120;
      counted = 0;
      while (counted < quota) begin
        r = $urandom_range(0, 99);
        if (r < 82) op = OP_TICK;
        else if (r < 92) op = OP_REARM;
        else if (r < 97) op = OP_RELEASE;
        else op = OpSpare;
        send_word(op, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0,
                  Predicted, Unused);
        if (op != OpSpare && !(op == OP_TICK && step_div == '0))
          counted = counted + 1;
      end
    end

    drain_results();
    repeat (Latency + 6) @(posedge clk_i);
    if (mismatch_count == 0 && motor_expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[halfstep_stepper_limit_sequencer.f]
hdl/hsls_pkg.sv
hdl/hsls_step.sv
hdl/halfstep_stepper_limit_sequencer.sv
verif/tb.sv
